### hw/rtl/mmds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmds_pkg
// Shared constants and types of the digit-serial Montgomery multiplier.
// ----------------------------------------------------------------------------
package mmds_pkg;

  // Width of the operand, modulus and product ports.
  localparam int FIELD_BITS   = 64;
  // Width of the modulus that takes part in the arithmetic.
  localparam int OPERAND_BITS = 64;
  // Width of one digit of operand a.
  localparam int DIGIT_BITS   = 4;
  // Width of the stored inverse digit register.
  localparam int NINV_BITS    = 4;

  // The accumulator stays below b + m, so one bit more than an operand is enough.
  localparam int ACC_BITS = OPERAND_BITS + 1;
  // The sum of the accumulator and two digit-by-word products before the shift.
  localparam int SUM_BITS = OPERAND_BITS + DIGIT_BITS + 2;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEG_INV = 1'b1;

  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = '1;
  localparam logic [NINV_BITS-1:0]  NEG_INV_RESET = NINV_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL
  } mmds_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } mmds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_zero;
    logic last_round;
  } mmds_status_t;

endpackage

### hw/rtl/mmds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmds_ctrl
// Sequencer: accepts an item, runs one round per digit, then hands the
// reduced result to the output register.
// ----------------------------------------------------------------------------
module mmds_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  mmds_pkg::mmds_status_t status_i,
  output mmds_pkg::mmds_cmd_t    cmd_o
);
  import mmds_pkg::*;

  mmds_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // A modulus of zero has no digits, so there are no rounds.
          state_d = status_i.mod_zero ? ST_FINAL : ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (status_i.last_round) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_ROUND: begin
        cmd_o.step = 1'b1;
      end
      ST_FINAL: begin
        cmd_o.finish = out_free;
      end
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/mmds_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmds_dp
// Datapath: configuration registers, operand shifters, the digit-by-word
// multiply-accumulate round and the final conditional subtraction.
// ----------------------------------------------------------------------------
module mmds_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [mmds_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  logic [mmds_pkg::FIELD_BITS-1:0]          cfg_data_i,
  input  logic [mmds_pkg::FIELD_BITS-1:0]          operand_a_i,
  input  logic [mmds_pkg::FIELD_BITS-1:0]          operand_b_i,
  input  mmds_pkg::mmds_cmd_t                      cmd_i,
  output mmds_pkg::mmds_status_t                   status_o,
  output logic [mmds_pkg::FIELD_BITS-1:0]          product_o
);
  import mmds_pkg::*;

  logic [FIELD_BITS-1:0]   modulus_q;
  logic [NINV_BITS-1:0]    ninv_q;

  logic [OPERAND_BITS-1:0] a_shift_q, a_shift_d;
  logic [OPERAND_BITS-1:0] m_shift_q, m_shift_d;
  logic [OPERAND_BITS-1:0] b_q, b_d;
  logic [ACC_BITS-1:0]     acc_q, acc_d;
  logic [FIELD_BITS-1:0]   product_q, product_d;

  logic [OPERAND_BITS-1:0]         m_op;
  logic [DIGIT_BITS-1:0]           a_digit;
  logic [DIGIT_BITS-1:0]           t_low;
  logic [DIGIT_BITS+NINV_BITS-1:0] q_wide;
  logic [DIGIT_BITS-1:0]           q_digit;
  logic [SUM_BITS-1:0]             sum;
  logic [ACC_BITS:0]               diff;
  logic [FIELD_BITS-1:0]           result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
      ninv_q    <= NEG_INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODULUS: modulus_q <= cfg_data_i;
        CFG_NEG_INV: ninv_q    <= cfg_data_i[NINV_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign m_op    = modulus_q[OPERAND_BITS-1:0];
  assign a_digit = a_shift_q[DIGIT_BITS-1:0];

  // Quotient digit from the low digits only, taken modulo the digit radix.
  assign t_low   = DIGIT_BITS'(acc_q[DIGIT_BITS-1:0] + a_digit * b_q[DIGIT_BITS-1:0]);
  assign q_wide  = (DIGIT_BITS+NINV_BITS)'(t_low) * (DIGIT_BITS+NINV_BITS)'(ninv_q);
  assign q_digit = q_wide[DIGIT_BITS-1:0];

  assign sum = SUM_BITS'(acc_q)
             + SUM_BITS'(b_q) * SUM_BITS'(a_digit)
             + SUM_BITS'(m_op) * SUM_BITS'(q_digit);

  // One conditional subtraction; the borrow bit tells whether acc is below m.
  assign diff   = (ACC_BITS+1)'(acc_q) - (ACC_BITS+1)'(m_op);
  assign result = diff[ACC_BITS] ? FIELD_BITS'(acc_q) : FIELD_BITS'(diff[ACC_BITS-1:0]);

  always_comb begin
    a_shift_d = a_shift_q;
    m_shift_d = m_shift_q;
    b_d       = b_q;
    acc_d     = acc_q;
    product_d = product_q;
    if (cmd_i.load) begin
      a_shift_d = operand_a_i[OPERAND_BITS-1:0];
      b_d       = operand_b_i[OPERAND_BITS-1:0];
      m_shift_d = m_op;
      acc_d     = '0;
    end else if (cmd_i.step) begin
      a_shift_d = a_shift_q >> DIGIT_BITS;
      m_shift_d = m_shift_q >> DIGIT_BITS;
      acc_d     = sum[DIGIT_BITS +: ACC_BITS];
    end
    if (cmd_i.finish) begin
      product_d = result;
    end
  end

  always_ff @(posedge clk_i) begin
    a_shift_q <= a_shift_d;
    m_shift_q <= m_shift_d;
    b_q       <= b_d;
    acc_q     <= acc_d;
    product_q <= product_d;
  end

  // The round count is the digit length of m: the last round is the one
  // after which no nonzero digit of m remains.
  assign status_o.last_round = ((m_shift_q >> DIGIT_BITS) == '0);
  assign status_o.mod_zero   = (m_op == '0);

  assign product_o = product_q;

endmodule

### hw/rtl/montgomery_mul_digit_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// montgomery_mul_digit_serial
// Radix-16 digit-serial Montgomery multiplier: product = a * b * R^-1 mod m.
// ----------------------------------------------------------------------------
// Sequence: an accepted item is loaded, runs one round per 4-bit digit of the
// modulus (16 digits for a full 64-bit modulus), then goes to the output register.
// No new item is accepted until the last one is in the output register; rounds
// use the single digit-by-word multiply-accumulate unit that runs one round a cycle.
// The result waits in an output register while the next item is accepted.
// Reset: modulus all ones, inverse digit 1, no item in flight.
module montgomery_mul_digit_serial (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mmds_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [mmds_pkg::FIELD_BITS-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [mmds_pkg::FIELD_BITS-1:0]      operand_a_i,
  input  logic [mmds_pkg::FIELD_BITS-1:0]      operand_b_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mmds_pkg::FIELD_BITS-1:0]      product_o
);
  import mmds_pkg::*;

  mmds_cmd_t    cmd;
  mmds_status_t status;

  assign cfg_ready_o = 1'b1;

  mmds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mmds_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .product_o   (product_o)
  );

endmodule
